>>> hw/rtl/cdec_pkg.sv
// Package for the chunked transfer decoder.
// Holds the item structs, result kinds, parse phases and the hex digit decode.
// No dependencies.
package cdec_pkg;

	// Longest size field, in hex digits, that a size line may carry (1 to 15).
	localparam int unsigned SIZE_DIGITS = 8;
	localparam logic [4:0]  SIZE_DIGITS_W = 5'(SIZE_DIGITS);

	localparam int unsigned SIZE_W = 32;
	localparam logic [3:0]  DIGIT_CNT_MAX = 4'd15;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [7:0] {
		PH_SIZE    = 8'b0000_0001,
		PH_SIZE_LF = 8'b0000_0010,
		PH_DATA    = 8'b0000_0100,
		PH_SKIP_A  = 8'b0000_1000,
		PH_SKIP_B  = 8'b0001_0000,
		PH_OPT_CR  = 8'b0010_0000,
		PH_OPT_LF  = 8'b0100_0000,
		PH_HALT    = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       restart;
	} body_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_byte;
	} res_item_t;

	// What the parser produces for one item: a result or none.
	typedef struct packed {
		logic      vld;
		res_item_t item;
	} step_res_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] b);
		hex_digit_t d;
		d.is_hex = 1'b0;
		d.value  = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			d.is_hex = 1'b1;
			d.value  = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			d.is_hex = 1'b1;
			d.value  = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			d.is_hex = 1'b1;
			d.value  = 4'(b - 8'h37);
		end
		return d;
	endfunction

endpackage

>>> hw/rtl/cdec_parser.sv
// Parse state and one-byte step logic of the chunked transfer decoder.
// Depends on cdec_pkg.
module cdec_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  cdec_pkg::body_item_t item,
	output cdec_pkg::step_res_t  res
);
	import cdec_pkg::*;

	phase_t              phase_q, phase_n;
	logic [SIZE_W-1:0]   size_accum_q, size_accum_n;
	logic [SIZE_W-1:0]   bytes_left_q, bytes_left_n;
	logic [3:0]          digit_count_q, digit_count_n;
	logic                digits_closed_q, digits_closed_n;

	// State as seen by this byte, after an optional restart.
	phase_t              ph;
	logic [SIZE_W-1:0]   acc, left;
	logic [3:0]          cnt;
	logic                closed;

	// Size line inputs; the optional CR slot starts a fresh line.
	logic [SIZE_W-1:0]   l_acc;
	logic [3:0]          l_cnt;
	logic                l_closed;

	hex_digit_t          hd;
	logic [SIZE_W-1:0]   left_dec;
	logic [7:0]          b;

	always_comb begin
		b        = item.in_byte;
		hd       = hex_decode(b);
		ph       = item.restart ? PH_SIZE : phase_q;
		acc      = item.restart ? '0 : size_accum_q;
		left     = item.restart ? '0 : bytes_left_q;
		cnt      = item.restart ? 4'd0 : digit_count_q;
		closed   = item.restart ? 1'b0 : digits_closed_q;
		l_acc    = (ph == PH_OPT_CR) ? '0 : acc;
		l_cnt    = (ph == PH_OPT_CR) ? 4'd0 : cnt;
		l_closed = (ph == PH_OPT_CR) ? 1'b0 : closed;
		left_dec = left - SIZE_W'(1);

		phase_n         = ph;
		size_accum_n    = acc;
		bytes_left_n    = left;
		digit_count_n   = cnt;
		digits_closed_n = closed;
		res.vld           = 1'b0;
		res.item.kind     = KIND_DATA;
		res.item.out_byte = 8'd0;

		unique case (ph)
			PH_SIZE_LF: begin
				if (b != CHAR_LF || cnt == 4'd0) begin
					phase_n = PH_HALT;
					res.vld = 1'b1;
					res.item.kind = KIND_ERR;
				end else if (acc == '0) begin
					phase_n = PH_HALT;
					res.vld = 1'b1;
					res.item.kind = KIND_END;
				end else begin
					bytes_left_n    = acc;
					size_accum_n    = '0;
					digit_count_n   = 4'd0;
					digits_closed_n = 1'b0;
					phase_n         = PH_DATA;
				end
			end
			PH_DATA: begin
				bytes_left_n = left_dec;
				if (left_dec == '0) begin
					phase_n = PH_SKIP_A;
				end
				res.vld = 1'b1;
				res.item.out_byte = b;
			end
			PH_SKIP_A: begin
				phase_n = PH_SKIP_B;
			end
			PH_SKIP_B: begin
				phase_n = PH_OPT_CR;
			end
			PH_OPT_LF: begin
				if (b == CHAR_LF) begin
					phase_n = PH_SIZE;
				end else begin
					phase_n = PH_HALT;
					res.vld = 1'b1;
					res.item.kind = KIND_ERR;
				end
			end
			PH_SIZE, PH_OPT_CR: begin
				size_accum_n    = l_acc;
				digit_count_n   = l_cnt;
				digits_closed_n = l_closed;
				if (b == CHAR_CR) begin
					phase_n = (ph == PH_OPT_CR) ? PH_OPT_LF : PH_SIZE_LF;
				end else begin
					phase_n = PH_SIZE;
					if (hd.is_hex && !l_closed) begin
						if ({1'b0, l_cnt} >= SIZE_DIGITS_W) begin
							phase_n = PH_HALT;
							res.vld = 1'b1;
							res.item.kind = KIND_ERR;
						end else begin
							// Saturate once a nonzero nibble would fall off the top.
							if (l_acc[SIZE_W-1 -: 4] != 4'd0) begin
								size_accum_n = '1;
							end else begin
								size_accum_n = {l_acc[SIZE_W-5:0], hd.value};
							end
							if (l_cnt < DIGIT_CNT_MAX) begin
								digit_count_n = l_cnt + 4'd1;
							end
						end
					end else begin
						digits_closed_n = 1'b1;
					end
				end
			end
			default: begin
				// Halted: bytes are dropped until a restart.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_SIZE;
			size_accum_q    <= '0;
			bytes_left_q    <= '0;
			digit_count_q   <= 4'd0;
			digits_closed_q <= 1'b0;
		end else if (step) begin
			phase_q         <= phase_n;
			size_accum_q    <= size_accum_n;
			bytes_left_q    <= bytes_left_n;
			digit_count_q   <= digit_count_n;
			digits_closed_q <= digits_closed_n;
		end
	end

endmodule

>>> hw/rtl/chunked_transfer_decoder.sv
// Top level of the chunked transfer decoder: input register, parser, result register.
// Depends on cdec_pkg and cdec_parser.
//
//   channel | signals                      | payload
//   --------+------------------------------+------------------------------
//   body    | body_valid / body_ready      | body_item_t {in_byte, restart}
//   res     | res_valid  / res_ready       | res_item_t  {kind, out_byte}
//
// Each byte is parsed while it sits in the input register, and its result, if
// any, is registered in the result register when the parse step runs; a stalled
// result register holds off that step.
// The block sustains one byte per clock while results are taken; the limit is
// the parse step, which reads and updates the parse state for each byte.
// A stalled result register holds the next byte in the input register, and
// body_ready drops only while both registers are full and the result is not taken.
// Reset puts the parser at the start of a size line with both registers empty.
module chunked_transfer_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  body_valid,
	output logic                  body_ready,
	input  cdec_pkg::body_item_t  body,
	output logic                  res_valid,
	input  logic                  res_ready,
	output cdec_pkg::res_item_t   res
);
	import cdec_pkg::*;

	// Input register: the byte waiting to be parsed.
	logic       body_valid_s1;
	body_item_t body_s1;

	// Result register.
	logic       res_valid_q;
	res_item_t  res_q;

	logic       step;
	step_res_t  step_res;

	// The parse step runs when there is a byte and room for what it may produce.
	assign step       = body_valid_s1 && (!res_valid_q || res_ready);
	assign body_ready = !body_valid_s1 || step;

	cdec_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (body_s1),
		.res    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_valid_s1 <= 1'b0;
		end else if (body_ready) begin
			body_valid_s1 <= body_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body_ready && body_valid) begin
			body_s1 <= body;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || res_ready) begin
			res_valid_q <= step && step_res.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (step && step_res.vld) begin
			res_q <= step_res.item;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// End and error results never carry a payload byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.kind != KIND_DATA) |-> (res_q.out_byte == 8'd0))
		else $error("non-data result carries a payload byte");

	// A stalled result keeps the next byte parked, unchanged, in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(body_valid_s1 && res_valid_q && !res_ready) |=> (body_valid_s1 && $stable(body_s1)))
		else $error("input register lost a byte during an output stall");

	// A new result appears only after a parse step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(step))
		else $error("result appeared without a parse step");

endmodule

>>> tb/chunked_transfer_decoder_test.sv
// Self-checking testbench for the chunked transfer decoder: a short stimulus table
// and then random chunked bodies, checked against a behavioral decoder model.
// Depends on cdec_pkg and chunked_transfer_decoder.
`timescale 1ns / 100ps

module chunked_transfer_decoder_test;
	import cdec_pkg::*;

	// One row of the stimulus table. When known is set, res is the result that
	// the row must produce, typed in by hand; otherwise the model decides.
	typedef struct packed {
		body_item_t item;
		bit         known;
		res_item_t  res;
	} plan_row_t;

	localparam res_item_t NO_RES  = '{KIND_DATA, 8'h00};
	localparam res_item_t END_RES = '{KIND_END, 8'h00};
	localparam res_item_t ERR_RES = '{KIND_ERR, 8'h00};
	localparam int        RANDOM_BYTES = 1750;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       body_valid = 1'b0;
	logic       body_ready;
	body_item_t body = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	res_item_t  res;

	// Decoder model state, one copy of the parse registers.
	phase_t      st_phase;
	logic [31:0] st_size;
	logic [31:0] st_left;
	logic [3:0]  st_ndig;
	logic        st_closed;

	// Results the decoder still owes us, oldest first.
	res_item_t decoded_q[$];

	plan_row_t plan [0:27];
	int        parsed_bytes = 0;
	int        bodies = 0;
	int        bad_results = 0;
	int        kind_count [3] = '{0, 0, 0};

	always #2 clk = ~clk;

	chunked_transfer_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.body_valid(body_valid),
		.body_ready(body_ready),
		.body      (body),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// During this window of the run neither side idles, so the decoder gets a
	// long stretch at full rate.
	function automatic bit quiet();
		return parsed_bytes >= 1000 && parsed_bytes < 1400;
	endfunction

	// Hex digit test. Folding the case bit maps both letter ranges onto 'a'..'f'.
	function automatic bit hex_nibble(input logic [7:0] b, output logic [3:0] v);
		logic [7:0] folded;
		folded = b | 8'h20;
		v = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = b[3:0];
			return 1'b1;
		end
		if (folded >= 8'h61 && folded <= 8'h66) begin
			v = folded[3:0] + 4'd9;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// One byte of a size line. A CR moves on to the LF check; leading hex digits
	// build the size; the first other byte closes the digit field for good.
	task automatic size_char(input logic [7:0] b, output bit got, output res_item_t r);
		logic [3:0] v;
		bit         hx;
		got = 1'b0;
		r = NO_RES;
		hx = hex_nibble(b, v);
		if (b == CHAR_CR) begin
			st_phase = PH_SIZE_LF;
		end else if (hx && !st_closed) begin
			if (st_ndig >= SIZE_DIGITS) begin
				st_phase = PH_HALT;
				got = 1'b1;
				r = ERR_RES;
			end else begin
				st_size = (st_size > 32'h0FFF_FFFF) ? 32'hFFFF_FFFF : {st_size[27:0], v};
				if (st_ndig != 4'd15)
					st_ndig++;
			end
		end else begin
			st_closed = 1'b1;
		end
	endtask

	// Advances the decoder model by one accepted byte and returns the result it
	// gives, if any.
	task automatic decode_byte(input body_item_t it, output bit got, output res_item_t r);
		logic [7:0] b;
		b = it.in_byte;
		got = 1'b0;
		r = NO_RES;
		if (it.restart) begin
			st_phase = PH_SIZE;
			st_left = '0;
			st_size = '0;
			st_ndig = '0;
			st_closed = 1'b0;
		end
		case (st_phase)
			PH_SIZE: begin
				size_char(b, got, r);
			end
			PH_SIZE_LF: begin
				if (b != CHAR_LF || st_ndig == 0) begin
					st_phase = PH_HALT;
					got = 1'b1;
					r = ERR_RES;
				end else if (st_size == 0) begin
					st_phase = PH_HALT;
					got = 1'b1;
					r = END_RES;
				end else begin
					st_left = st_size;
					st_size = '0;
					st_ndig = '0;
					st_closed = 1'b0;
					st_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				st_left = st_left - 1;
				if (st_left == 0)
					st_phase = PH_SKIP_A;
				got = 1'b1;
				r.kind = KIND_DATA;
				r.out_byte = b;
			end
			PH_SKIP_A: begin
				st_phase = PH_SKIP_B;
			end
			PH_SKIP_B: begin
				st_phase = PH_OPT_CR;
			end
			PH_OPT_CR: begin
				st_size = '0;
				st_ndig = '0;
				st_closed = 1'b0;
				if (b == CHAR_CR) begin
					st_phase = PH_OPT_LF;
				end else begin
					st_phase = PH_SIZE;
					size_char(b, got, r);
				end
			end
			PH_OPT_LF: begin
				if (b == CHAR_LF) begin
					st_phase = PH_SIZE;
				end else begin
					st_phase = PH_HALT;
					got = 1'b1;
					r = ERR_RES;
				end
			end
			default: begin
			end
		endcase
	endtask

	// Offers one item on the body channel and holds it until it is taken. The
	// model is advanced at the accepting edge, so expectations queue up in the
	// same order as the decoder sees the bytes. Bytes that land on a halted
	// parser are not counted, as the decoder does nothing with them.
	task automatic put_row(input plan_row_t rw);
		bit        got;
		res_item_t r;
		while (!quiet() && $urandom_range(99) < 6) begin
			body_valid <= 1'b0;
			@(posedge clk);
		end
		body_valid <= 1'b1;
		body <= rw.item;
		do
			@(posedge clk);
		while (!body_ready);
		if (rw.item.restart || st_phase != PH_HALT)
			parsed_bytes++;
		decode_byte(rw.item, got, r);
		if (rw.known)
			decoded_q.insert(decoded_q.size(), rw.res);
		else if (got)
			decoded_q.insert(decoded_q.size(), r);
	endtask

	task automatic send(input logic [7:0] b, input bit rs);
		plan_row_t rw;
		rw.item.in_byte = b;
		rw.item.restart = rs;
		rw.known = 1'b0;
		rw.res = NO_RES;
		put_row(rw);
	endtask

	// A hex digit as text, letters in either case.
	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 10)
			return 8'h30 + 8'(v);
		return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
	endfunction

	// A byte that is neither a hex digit, CR nor LF.
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		logic [3:0] v;
		b = 8'($urandom_range(255));
		while (hex_nibble(b, v) || b == CHAR_CR || b == CHAR_LF)
			b = 8'($urandom_range(255));
		return b;
	endfunction

	// A well-formed size line: optional leading zeros, the digits, sometimes an
	// extension (which may start with a bare LF), then CR LF.
	task automatic size_line(input logic [31:0] sz, input bit rs);
		int         nd;
		int         pad;
		int         k;
		logic [7:0] b;
		nd = 1;
		while (nd < 8 && (sz >> (4 * nd)) != 0)
			nd++;
		pad = ($urandom_range(3) == 0) ? $urandom_range(SIZE_DIGITS - nd) : 0;
		for (k = 0; k < pad; k++)
			send(8'h30, rs && k == 0);
		for (k = nd - 1; k >= 0; k--)
			send(hex_char(4'(sz >> (4 * k))), rs && pad == 0 && k == nd - 1);
		if ($urandom_range(9) < 3) begin
			send(($urandom_range(4) == 0) ? CHAR_LF : plain_byte(), 1'b0);
			repeat ($urandom_range(4)) begin
				b = 8'($urandom_range(255));
				send((b == CHAR_CR) ? CHAR_LF : b, 1'b0);
			end
		end
		send(CHAR_CR, 1'b0);
		send(CHAR_LF, 1'b0);
	endtask

	// One body, normally starting with a restart. Most are clean chunk sequences
	// with a zero chunk at the end; the rest are noise, a huge chunk cut short, or
	// end in one of the broken forms the decoder must flag.
	task automatic gen_body();
		int         mode;
		int         chunks;
		int         c;
		int         k;
		int         sz;
		bit         rs;
		logic [7:0] b;
		mode = $urandom_range(99);
		rs = 1'b1;
		bodies++;
		if (mode < 8) begin
			// Noise heavy in digits, CR and LF.
			sz = $urandom_range(1, 12);
			for (k = 0; k < sz; k++) begin
				case ($urandom_range(3))
					0: b = hex_char(4'($urandom_range(15)));
					1: b = CHAR_CR;
					2: b = CHAR_LF;
					default: b = 8'($urandom_range(255));
				endcase
				send(b, k == 0);
			end
			return;
		end
		chunks = $urandom_range(3);
		for (c = 0; c < chunks; c++) begin
			sz = ($urandom_range(9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 64);
			size_line(sz, rs);
			rs = 1'b0;
			for (k = 0; k < sz; k++)
				send(8'($urandom_range(255)), 1'b0);
			// The two delimiter bytes are skipped whatever they hold.
			if ($urandom_range(9) < 8) begin
				send(CHAR_CR, 1'b0);
				send(CHAR_LF, 1'b0);
			end else begin
				send(8'($urandom_range(255)), 1'b0);
				send(8'($urandom_range(255)), 1'b0);
			end
			if (mode >= 18 && mode < 21 && c == chunks - 1) begin
				// Optional CR that is not followed by LF.
				send(CHAR_CR, 1'b0);
				send(plain_byte(), 1'b0);
				return;
			end
			if ($urandom_range(9) < 4) begin
				send(CHAR_CR, 1'b0);
				send(CHAR_LF, 1'b0);
			end
		end
		if (mode < 12) begin
			// One digit more than the size field may hold.
			for (k = 0; k <= SIZE_DIGITS; k++)
				send(hex_char(4'($urandom_range(15))), rs && k == 0);
			send(CHAR_CR, 1'b0);
			send(CHAR_LF, 1'b0);
		end else if (mode < 15) begin
			send(hex_char(4'($urandom_range(1, 15))), rs);
			send(CHAR_CR, 1'b0);
			send(plain_byte(), 1'b0);
		end else if (mode < 18) begin
			// Size line without a single digit.
			if ($urandom_range(1))
				send(plain_byte(), rs);
			send(CHAR_CR, rs && chunks == 0 && mode == 15);
			send(CHAR_LF, 1'b0);
		end else if (mode >= 21 && mode < 25) begin
			// A huge chunk cut short by the next restart.
			size_line($urandom_range(1) ? 32'hFFFF_FFFF : $urandom, rs);
			repeat ($urandom_range(1, 20))
				send(8'($urandom_range(255)), 1'b0);
		end else begin
			size_line(32'd0, rs);
			repeat ($urandom_range(3))
				send(8'($urandom_range(255)), 1'b0);
		end
	endtask

	// Result checker: every accepted result is matched against the oldest
	// outstanding expectation.
	always @(posedge clk) begin
		res_item_t want;
		if (arst_n && res_valid && res_ready) begin
			if (res.kind <= KIND_ERR)
				kind_count[res.kind]++;
			if (decoded_q.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("%0t: result kind %0d byte %h with nothing outstanding",
						$realtime, res.kind, res.out_byte);
			end else begin
				want = decoded_q.pop_front();
				if (res.kind !== want.kind || res.out_byte !== want.out_byte) begin
					bad_results++;
					if (bad_results <= 10)
						$display("%0t: want kind %0d byte %h, got kind %0d byte %h",
							$realtime, want.kind, want.out_byte, res.kind, res.out_byte);
				end
			end
		end
	end

	// Result side. It stalls now and then, except in the quiet window, and
	// once holds off for a long stretch so that both decoder registers fill
	// and body_ready has to drop while the sender keeps offering bytes.
	initial begin
		int k;
		bit held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && parsed_bytes >= 600) begin
				held = 1'b1;
				res_ready <= 1'b0;
				for (k = 0; k < 300; k++)
					@(posedge clk);
			end else begin
				res_ready <= quiet() || ($urandom_range(99) >= 6);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Run timed out with %0d results outstanding", decoded_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int k;
		int first_random;
		st_phase = PH_SIZE;
		st_size = '0;
		st_left = '0;
		st_ndig = '0;
		st_closed = 1'b0;

		// Hand-written bodies. The first walks a whole chunk: a bare LF that
		// closes the digits, a hex digit after them taken as text, the 0xFF data
		// byte, the delimiters, the optional CR LF, the zero chunk and a byte
		// dropped after the end. Then a lone CR, a line with no digits, and a
		// size field one digit too long.
		plan = '{
			'{'{8'h31, 1'b1}, 1'b0, NO_RES},
			'{'{8'h0A, 1'b0}, 1'b0, NO_RES},
			'{'{8'h35, 1'b0}, 1'b0, NO_RES},
			'{'{8'h0D, 1'b0}, 1'b0, NO_RES},
			'{'{8'h0A, 1'b0}, 1'b0, NO_RES},
			'{'{8'hFF, 1'b0}, 1'b1, '{KIND_DATA, 8'hFF}},
			'{'{8'h0D, 1'b0}, 1'b0, NO_RES},
			'{'{8'h0A, 1'b0}, 1'b0, NO_RES},
			'{'{8'h0D, 1'b0}, 1'b0, NO_RES},
			'{'{8'h0A, 1'b0}, 1'b0, NO_RES},
			'{'{8'h30, 1'b0}, 1'b0, NO_RES},
			'{'{8'h0D, 1'b0}, 1'b0, NO_RES},
			'{'{8'h0A, 1'b0}, 1'b1, END_RES},
			'{'{8'h00, 1'b0}, 1'b0, NO_RES},
			'{'{8'h41, 1'b1}, 1'b0, NO_RES},
			'{'{8'h0D, 1'b0}, 1'b0, NO_RES},
			'{'{8'h5A, 1'b0}, 1'b1, ERR_RES},
			'{'{8'h0D, 1'b1}, 1'b0, NO_RES},
			'{'{8'h0A, 1'b0}, 1'b1, ERR_RES},
			'{'{8'h46, 1'b1}, 1'b0, NO_RES},
			'{'{8'h66, 1'b0}, 1'b0, NO_RES},
			'{'{8'h66, 1'b0}, 1'b0, NO_RES},
			'{'{8'h66, 1'b0}, 1'b0, NO_RES},
			'{'{8'h66, 1'b0}, 1'b0, NO_RES},
			'{'{8'h66, 1'b0}, 1'b0, NO_RES},
			'{'{8'h66, 1'b0}, 1'b0, NO_RES},
			'{'{8'h66, 1'b0}, 1'b0, NO_RES},
			'{'{8'h66, 1'b0}, 1'b1, ERR_RES}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < $size(plan); k++)
			put_row(plan[k]);

		first_random = parsed_bytes;
		while (parsed_bytes - first_random < RANDOM_BYTES)
			gen_body();
		body_valid <= 1'b0;

		// Wait until no result is outstanding.
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Decoded %0d bodies, %0d parsed bytes in all.", bodies, parsed_bytes);
		$display("Results seen: %0d data, %0d end, %0d error; %0d mismatches.",
			kind_count[0], kind_count[1], kind_count[2], bad_results);
		if (bad_results == 0 && decoded_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> chunked_transfer_decoder.f
hw/rtl/cdec_pkg.sv
hw/rtl/cdec_parser.sv
hw/rtl/chunked_transfer_decoder.sv
tb/chunked_transfer_decoder_test.sv
